// ===== src/ppp_pkg.sv =====
// types, codes and constants shared by the pinhole projection block
// no dependencies
package ppp_pkg;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         word_index;
        logic signed [31:0] word_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } ppp_in_t;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic [1:0]         status;
        logic               end_of_landmark;
    } ppp_out_t;

    localparam logic [1:0] OP_SENSOR   = 2'd0;
    localparam logic [1:0] OP_LANDMARK = 2'd1;
    localparam logic [1:0] OP_SCALE    = 2'd2;
    localparam logic [1:0] OP_PROJECT  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEHIND = 2'd1;
    localparam logic [1:0] ST_OUT    = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    localparam logic [2:0] REG_FX = 3'd0;
    localparam logic [2:0] REG_FY = 3'd1;
    localparam logic [2:0] REG_CX = 3'd2;
    localparam logic [2:0] REG_CY = 3'd3;
    localparam logic [2:0] REG_SK = 3'd4;
    localparam logic [2:0] REG_W  = 3'd5;
    localparam logic [2:0] REG_H  = 3'd6;
    localparam logic [2:0] REG_MD = 3'd7;

    typedef struct packed {
        logic       load_point;  // capture input point
        logic       scale_step;  // p[sel] = sat(floor(x*scale))
        logic       row_start;   // acc = translation of row
        logic       mac;         // acc += floor(m*p)
        logic       row_end;     // dst[row] = sat(acc)
        logic       pose_sel;    // 0 landmark, 1 sensor
        logic [1:0] row;
        logic [1:0] col;
        logic       num_start;   // build numerator (0 u, 1 v)
        logic       num_v;
        logic       div_start;
        logic       finish;      // compute status and result
    } ppp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic fail;
    } ppp_sts_t;

endpackage

// ===== src/ppp_datapath.sv =====
// datapath: point registers, shared multiplier, restoring divider, status logic
// depends on ppp_pkg
module ppp_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ppp_pkg::ppp_in_t      in_item,
    input  logic                  load_word,
    input  ppp_pkg::ppp_cmd_t     cmd,
    output ppp_pkg::ppp_sts_t     sts,
    output ppp_pkg::ppp_out_t     result,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_idx,
    input  logic [31:0]           cfg_data
);
    import ppp_pkg::*;

    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam logic [30:0] MIN_D_RST = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [30:0] FX_RST = 31'(64'd500 << FRAC_BITS);
    localparam logic [30:0] CX_RST = 31'(64'd320 << FRAC_BITS);
    localparam logic [30:0] CY_RST = 31'(64'd240 << FRAC_BITS);

    logic signed [31:0] spose_reg [12];
    logic signed [31:0] lpose_reg [12];
    logic signed [31:0] scale_reg [3];
    logic [30:0] fx_reg, fy_reg, cx_reg, cy_reg, md_reg;
    logic signed [31:0] sk_reg;
    logic [15:0] w_reg, h_reg;

    logic signed [31:0] pt_reg [3];
    logic signed [31:0] wp_reg [3];
    logic signed [31:0] cp_reg [3];
    // row sum kept at full width, saturated once at the row end
    logic signed [63:0] acc_reg;
    logic last_reg;

    // multiplier operands
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [63:0] prod_fl;
    logic signed [31:0] scl_sat;
    logic signed [63:0] acc_sum;
    logic signed [31:0] acc_sat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFFFFFF;
        if (x < -64'sh0000_0000_8000_0000) return 32'sh80000000;
        return x[31:0];
    endfunction

    always_comb begin
        ma = '0;
        mb = '0;
        if (cmd.scale_step) begin
            ma = pt_reg[cmd.col];
            mb = scale_reg[cmd.col];
        end else begin
            ma = cmd.pose_sel ? spose_reg[{cmd.row, 2'b00} + {2'b00, cmd.col}]
                              : lpose_reg[{cmd.row, 2'b00} + {2'b00, cmd.col}];
            mb = cmd.pose_sel ? wp_reg[cmd.col] : pt_reg[cmd.col];
        end
    end
    assign prod    = 64'(ma) * 64'(mb);
    assign prod_fl = prod >>> FRAC_BITS;  // arithmetic shift floors
    assign scl_sat = sat32(prod_fl);
    assign acc_sum = acc_reg + prod_fl;
    assign acc_sat = sat32(acc_reg);

    // numerator and divider
    logic signed [63:0] num_reg;
    logic [63:0] rem_reg, quo_reg;
    logic [31:0] den_reg;
    logic neg_reg;
    logic [6:0] dcnt_reg;
    logic div_busy_reg;
    logic signed [63:0] numx;
    logic [64:0] trial;
    logic [63:0] rem_sh;

    always_comb begin
        numx = '0;
        if (cmd.num_start) begin
            if (cmd.num_v)
                numx = 64'($signed({1'b0, fy_reg})) * 64'(cp_reg[1]);
            else
                numx = 64'($signed({1'b0, fx_reg})) * 64'(cp_reg[0])
                     + 64'(sk_reg) * 64'(cp_reg[1]);
        end
    end
    assign rem_sh = {rem_reg[62:0], quo_reg[63]};
    assign trial  = {1'b0, rem_sh} - {33'd0, den_reg};

    // saturated pixel
    function automatic logic signed [31:0] pix(input logic signed [64:0] q,
                                               input logic [30:0] c,
                                               output logic s);
        logic signed [64:0] qc;
        logic signed [64:0] lim;
        lim = 65'sd1 <<< 40;
        s = 1'b0;
        qc = q;
        if (q > lim) begin qc = lim; s = 1'b1; end
        if (q < -lim) begin qc = -lim; s = 1'b1; end
        qc = qc + $signed({34'd0, c});
        if (qc > 65'sh07FFFFFFF) begin s = 1'b1; return 32'sh7FFFFFFF; end
        if (qc < -65'sh080000000) begin s = 1'b1; return 32'sh80000000; end
        return qc[31:0];
    endfunction

    logic signed [64:0] qsigned;
    assign qsigned = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    logic signed [31:0] u_reg;
    logic su_reg, sv_reg;
    logic signed [31:0] pu;
    logic spu;
    // u quotient is taken while the v numerator is built, so it still uses cx
    always_comb pu = pix(qsigned, (cmd.num_v && !cmd.num_start) ? cy_reg : cx_reg, spu);

    logic [1:0] st;
    logic signed [31:0] ufin, vfin;
    always_comb begin
        ufin = (cp_reg[2] == 0) ? 32'sd0 : u_reg;
        vfin = (cp_reg[2] == 0) ? 32'sd0 : pu;
        if (cp_reg[2] < $signed({1'b0, md_reg}))
            st = ST_BEHIND;
        else if (cp_reg[2] == 0)
            st = ST_ZERO;
        else if (su_reg || spu || ufin < 0 || vfin < 0 ||
                 48'(ufin) > $signed(48'(w_reg) << FRAC_BITS) ||
                 48'(vfin) > $signed(48'(h_reg) << FRAC_BITS))
            st = ST_OUT;
        else
            st = ST_OK;
    end

    assign sts.div_busy = div_busy_reg;
    assign sts.fail     = (st != ST_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 12; i++) begin
                spose_reg[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q : '0;
                lpose_reg[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q : '0;
            end
            for (int i = 0; i < 3; i++) scale_reg[i] <= ONE_Q;
            fx_reg <= FX_RST;
            fy_reg <= FX_RST;
            cx_reg <= CX_RST;
            cy_reg <= CY_RST;
            sk_reg <= '0;
            w_reg  <= 16'd640;
            h_reg  <= 16'd480;
            md_reg <= MIN_D_RST;
            div_busy_reg <= 1'b0;
        end else begin
            if (load_word) begin
                case (in_item.operation)
                    OP_SENSOR: begin
                        if (in_item.word_index < 4'd12)
                            spose_reg[in_item.word_index] <= in_item.word_value;
                    end
                    OP_LANDMARK: begin
                        if (in_item.word_index < 4'd12)
                            lpose_reg[in_item.word_index] <= in_item.word_value;
                    end
                    OP_SCALE: begin
                        if (in_item.word_index < 4'd3)
                            scale_reg[in_item.word_index[1:0]] <= in_item.word_value;
                    end
                    default: ;
                endcase
            end
            if (cfg_we) begin
                case (cfg_idx)
                    REG_FX: fx_reg <= cfg_data[30:0];
                    REG_FY: fy_reg <= cfg_data[30:0];
                    REG_CX: cx_reg <= cfg_data[30:0];
                    REG_CY: cy_reg <= cfg_data[30:0];
                    REG_SK: sk_reg <= cfg_data;
                    REG_W:  w_reg  <= cfg_data[15:0];
                    REG_H:  h_reg  <= cfg_data[15:0];
                    REG_MD: md_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cmd.div_start && cp_reg[2] != 0) begin
                div_busy_reg <= 1'b1;
            end else if (div_busy_reg && dcnt_reg == 7'd63) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            pt_reg[0] <= in_item.point_x;
            pt_reg[1] <= in_item.point_y;
            pt_reg[2] <= in_item.point_z;
            last_reg  <= in_item.last_point;
        end
        if (cmd.scale_step) pt_reg[cmd.col] <= scl_sat;
        if (cmd.row_start)
            acc_reg <= 64'(cmd.pose_sel ? spose_reg[{cmd.row, 2'b11}]
                                        : lpose_reg[{cmd.row, 2'b11}]);
        if (cmd.mac)
            acc_reg <= acc_sum;
        if (cmd.row_end) begin
            if (cmd.pose_sel) cp_reg[cmd.row] <= acc_sat;
            else              wp_reg[cmd.row] <= acc_sat;
        end
        if (cmd.num_start) num_reg <= numx;
        if (cmd.div_start) begin
            neg_reg  <= num_reg[63] ^ cp_reg[2][31];
            quo_reg  <= num_reg[63] ? 64'(-num_reg) : num_reg;
            rem_reg  <= '0;
            den_reg  <= cp_reg[2][31] ? 32'(-cp_reg[2]) : cp_reg[2];
            dcnt_reg <= '0;
        end else if (div_busy_reg) begin
            // one quotient bit a cycle, dividend shifted through quo_reg
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 7'd1;
        end
        if (cmd.num_start && cmd.num_v) begin
            u_reg  <= pu;
            su_reg <= spu;
        end
        if (cmd.finish) begin
            result.pixel_u         <= ufin;
            result.pixel_v         <= vfin;
            result.status          <= st;
            result.end_of_landmark <= last_reg || (st != ST_OK);
        end
    end

endmodule

// ===== src/ppp_control.sv =====
// sequencer for the projection: scale, two transforms, two divides, result
// depends on ppp_pkg
module ppp_control (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ppp_pkg::ppp_in_t      s_item,
    output logic                  load_word,
    output ppp_pkg::ppp_cmd_t     cmd,
    input  ppp_pkg::ppp_sts_t     sts,
    output logic                  m_valid,
    input  logic                  m_ready
);
    import ppp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_XFORM = 3'd2;
    localparam logic [2:0] S_NUM   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] row_reg, row_next, col_reg, col_next;
    logic [1:0] ph_reg, ph_next;   // row phase: start, three macs, end
    logic pose_reg, pose_next, nv_reg, nv_next, drop_reg, drop_next;
    logic last_reg, last_next;
    logic mv_reg, mv_next;
    logic acc;

    assign s_ready   = (state_reg == S_IDLE) && !mv_reg;
    assign acc       = s_valid && s_ready;
    assign load_word = acc && (s_item.operation != OP_PROJECT);
    assign m_valid   = mv_reg;

    always_comb begin
        state_next = state_reg;
        row_next = row_reg; col_next = col_reg; ph_next = ph_reg;
        pose_next = pose_reg; nv_next = nv_reg; drop_next = drop_reg;
        last_next = last_reg;
        mv_next = mv_reg && !m_ready;
        cmd = '0;
        cmd.row = row_reg;
        cmd.col = col_reg;
        cmd.pose_sel = pose_reg;
        cmd.num_v = nv_reg;
        case (state_reg)
            S_IDLE: begin
                if (acc && s_item.operation == OP_PROJECT) begin
                    if (drop_reg) begin
                        if (s_item.last_point) drop_next = 1'b0;
                    end else begin
                        cmd.load_point = 1'b1;
                        last_next  = s_item.last_point;
                        col_next   = 2'd0;
                        state_next = S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                cmd.scale_step = 1'b1;
                if (col_reg == 2'd2) begin
                    col_next = 2'd0; row_next = 2'd0; ph_next = 2'd0;
                    pose_next = 1'b0;
                    state_next = S_XFORM;
                end else col_next = col_reg + 2'd1;
            end
            S_XFORM: begin
                if (ph_reg == 2'd0) begin
                    cmd.row_start = 1'b1;
                    ph_next = 2'd1; col_next = 2'd0;
                end else if (ph_reg == 2'd1) begin
                    cmd.mac = 1'b1;
                    if (col_reg == 2'd2) ph_next = 2'd2;
                    else col_next = col_reg + 2'd1;
                end else begin
                    cmd.row_end = 1'b1;
                    ph_next = 2'd0;
                    if (row_reg == 2'd2) begin
                        row_next = 2'd0;
                        if (pose_reg) begin
                            nv_next = 1'b0;
                            state_next = S_NUM;
                        end else pose_next = 1'b1;
                    end else row_next = row_reg + 2'd1;
                end
            end
            S_NUM: begin
                cmd.num_start = 1'b1;
                state_next = S_DIV;
                ph_next = 2'd0;
            end
            S_DIV: begin
                if (ph_reg == 2'd0) begin
                    cmd.div_start = 1'b1;
                    ph_next = 2'd1;
                end else if (ph_reg == 2'd1) begin
                    ph_next = 2'd2;   // let busy rise
                end else if (!sts.div_busy) begin
                    if (nv_reg) state_next = S_FIN;
                    else begin
                        nv_next = 1'b1;
                        state_next = S_NUM;
                    end
                end
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                if (sts.fail && !last_reg) drop_next = 1'b1;
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            row_reg <= '0; col_reg <= '0; ph_reg <= '0;
            pose_reg <= 1'b0; nv_reg <= 1'b0; drop_reg <= 1'b0;
            last_reg <= 1'b0; mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg <= row_next; col_reg <= col_next; ph_reg <= ph_next;
            pose_reg <= pose_next; nv_reg <= nv_next; drop_reg <= drop_next;
            last_reg <= last_next; mv_reg <= mv_next;
        end
    end

endmodule

// ===== src/pinhole_point_projection.sv =====
// top level of the pinhole point projection block
// depends on ppp_pkg, ppp_control, ppp_datapath
//
// Input channel s_*: one item per transfer; load operations write a pose or
// scale word and give no result; a project operation gives at most one
// result on m_*. Points that follow a failing point are dropped up to and
// including the one marked last.
// Configuration channel cfg_*: register index and data, always ready.
// A projection runs through one shared 32x32 multiplier, which steps through the
// scale and both 3x4 transforms one product a cycle; each pixel quotient takes
// a numerator step, a restoring divider that forms one quotient bit a cycle and
// control steps that start the divider and wait for it (the divider is skipped
// when the depth is zero). A new item is taken only once the projection before
// it has finished.
// The result waits in an output register; no new item is taken until it has
// been transferred, so a stalled receiver holds the input side.
// Reset (aresetn low, synchronous) restores identity poses, unit scale and
// default intrinsics and clears the drop flag.
module pinhole_point_projection #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ppp_pkg::ppp_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ppp_pkg::ppp_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import ppp_pkg::*;

    ppp_cmd_t cmd;
    ppp_sts_t sts;
    logic     load_word;

    assign cfg_ready = 1'b1;

    ppp_control u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item(s_data), .load_word,
        .cmd, .sts, .m_valid, .m_ready
    );

    ppp_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .in_item(s_data), .load_word, .cmd, .sts,
        .result(m_data), .cfg_we(cfg_valid), .cfg_idx(cfg_index),
        .cfg_data
    );

endmodule

// ===== sim/ppp_checker.sv =====
// checker for the pinhole point projection block: predicts each result and
// compares it with the transfers seen on m_*; depends on ppp_pkg
module ppp_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  ppp_pkg::ppp_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  ppp_pkg::ppp_out_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output int                fail_count,
    output int                pending
);
    import ppp_pkg::*;

    localparam int FB = 16;
    localparam longint QLIM = 64'sd1 << 40;

    longint sens [12];
    longint lmk [12];
    longint scl [3];
    bit     dropping;
    longint fx, fy, cx, cy, sk, iw, ih, md;

    ppp_out_t pixel_q[$];

    function automatic longint fl(longint v);
        return v >>> FB;
    endfunction

    function automatic longint sat(longint v, inout bit s);
        if (v > 64'sd2147483647) begin
            s = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            s = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    task automatic reset_state();
        for (int i = 0; i < 12; i++) begin
            sens[i] = 0;
            lmk[i] = 0;
        end
        sens[0] = 65536; sens[5] = 65536; sens[10] = 65536;
        lmk[0] = 65536; lmk[5] = 65536; lmk[10] = 65536;
        for (int i = 0; i < 3; i++) scl[i] = 65536;
        dropping = 0;
        fx = 500 << FB; fy = 500 << FB; cx = 320 << FB; cy = 240 << FB;
        sk = 0; iw = 640; ih = 480; md = 6554;
    endtask

    function automatic longint pix(longint num, longint den, longint c, inout bit s);
        longint q;
        q = num / den;
        if (q > QLIM) begin q = QLIM; s = 1; end
        if (q < -QLIM) begin q = -QLIM; s = 1; end
        return sat(q + c, s);
    endfunction

    task automatic project(ppp_in_t it);
        longint p[3], w[3], c[3], acc, u, v;
        bit s, d;
        ppp_out_t r;
        s = 0; d = 0; u = 0; v = 0;
        p[0] = sat(fl(longint'(it.point_x) * scl[0]), d);
        p[1] = sat(fl(longint'(it.point_y) * scl[1]), d);
        p[2] = sat(fl(longint'(it.point_z) * scl[2]), d);
        for (int i = 0; i < 3; i++) begin
            acc = lmk[i*4+3];
            for (int j = 0; j < 3; j++) acc += fl(lmk[i*4+j] * p[j]);
            w[i] = sat(acc, d);
        end
        for (int i = 0; i < 3; i++) begin
            acc = sens[i*4+3];
            for (int j = 0; j < 3; j++) acc += fl(sens[i*4+j] * w[j]);
            c[i] = sat(acc, d);
        end
        if (c[2] != 0) begin
            u = pix(fx * c[0] + sk * c[1], c[2], cx, s);
            v = pix(fy * c[1], c[2], cy, s);
        end
        if (c[2] < md) r.status = ST_BEHIND;
        else if (c[2] == 0) r.status = ST_ZERO;
        else if (s || u < 0 || v < 0 || u > (iw << FB) || v > (ih << FB))
            r.status = ST_OUT;
        else r.status = ST_OK;
        if (r.status != ST_OK && !it.last_point) dropping = 1;
        r.pixel_u = u[31:0];
        r.pixel_v = v[31:0];
        r.end_of_landmark = it.last_point || r.status != ST_OK;
        pixel_q = {pixel_q, r};
    endtask

    task automatic mismatch(string what, ppp_out_t e, ppp_out_t a);
        fail_count++;
        if (fail_count <= 10) begin
            $write("mismatch %s: expected u=%h v=%h st=%0d eol=%0d, ",
                   what, e.pixel_u, e.pixel_v, e.status, e.end_of_landmark);
            $display("got u=%h v=%h st=%0d eol=%0d",
                     a.pixel_u, a.pixel_v, a.status, a.end_of_landmark);
        end
    endtask

    initial begin
        fail_count = 0;
        reset_state();
    end

    assign pending = pixel_q.size();

    always @(posedge aclk) begin
        ppp_out_t e;
        if (!aresetn) begin
            reset_state();
            pixel_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FX: fx = longint'(cfg_data[30:0]);
                    REG_FY: fy = longint'(cfg_data[30:0]);
                    REG_CX: cx = longint'(cfg_data[30:0]);
                    REG_CY: cy = longint'(cfg_data[30:0]);
                    REG_SK: sk = longint'(signed'(cfg_data));
                    REG_W:  iw = longint'(cfg_data[15:0]);
                    REG_H:  ih = longint'(cfg_data[15:0]);
                    REG_MD: md = longint'(cfg_data[30:0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    e = '0;
                    mismatch("unexpected transfer", e, m_data);
                end else begin
                    e = pixel_q.pop_front();
                    if (m_data !== e) mismatch("result", e, m_data);
                end
            end
            if (s_valid && s_ready) begin
                case (s_data.operation)
                    OP_SENSOR:
                        if (s_data.word_index < 12)
                            sens[s_data.word_index] = longint'(s_data.word_value);
                    OP_LANDMARK:
                        if (s_data.word_index < 12)
                            lmk[s_data.word_index] = longint'(s_data.word_value);
                    OP_SCALE:
                        if (s_data.word_index < 3)
                            scl[s_data.word_index] = longint'(s_data.word_value);
                    default:
                        if (dropping) begin
                            if (s_data.last_point) dropping = 0;
                        end else begin
                            project(s_data);
                        end
                endcase
            end
        end
    end
endmodule

// ===== sim/testbench.sv =====
// stimulus and verdict for the pinhole point projection block
// depends on ppp_pkg, pinhole_point_projection and ppp_checker
module testbench;
    import ppp_pkg::*;

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    ppp_in_t   s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    ppp_out_t  m_data;
    logic      cfg_valid = 0;
    logic      cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int        fail_count;
    int        pending;
    int        send_idle = 0;
    int        recv_stall = 0;
    longint    cycles = 0;

    pinhole_point_projection dut (.*);

    ppp_checker chk (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("FAIL pinhole_point_projection");
            $finish;
        end
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall);

    // valid stays up after a transfer until the next item or an idle cycle
    task automatic send(ppp_in_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
        endcase
    endfunction

    function automatic ppp_in_t load_item(logic [1:0] op, int idx, logic [31:0] val);
        ppp_in_t it;
        it = '0;
        it.operation = op;
        it.word_index = 4'(idx);
        it.word_value = val;
        it.point_x = $urandom();
        it.last_point = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic ppp_in_t point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      bit last);
        ppp_in_t it;
        it = '0;
        it.operation = OP_PROJECT;
        it.word_index = 4'($urandom());
        it.word_value = $urandom();
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        it.last_point = last;
        return it;
    endfunction

    // a plausible pose: near-identity rotation, modest translation, depth ahead
    task automatic load_pose(logic [1:0] op);
        for (int i = 0; i < 12; i++) begin
            logic [31:0] val;
            if (i == 0 || i == 5 || i == 10)
                val = 32'h0001_0000 + $urandom_range(8000) - 4000;
            else if (i == 11)
                val = (op == OP_SENSOR) ? 32'h0005_0000 + $urandom_range(32'h8_0000)
                                        : $urandom_range(32'h2_0000);
            else if (i == 3 || i == 7) val = $urandom_range(32'h2_0000) - 32'h1_0000;
            else val = $urandom_range(8000) - 4000;
            send(load_item(op, i, val));
        end
    endtask

    task automatic random_phase(int n);
        int k;
        k = 0;
        while (k < n) begin
            case ($urandom_range(9))
                0: begin
                    send(load_item(2'($urandom_range(2)), $urandom_range(15), rnd_word()));
                    k++;
                end
                1: begin
                    load_pose(2'($urandom_range(1)));
                    k += 12;
                end
                2: begin
                    send(load_item(OP_SCALE, $urandom_range(2),
                                   32'h0000_8000 + $urandom_range(32'h1_8000)));
                    k++;
                end
                3: begin
                    send(point(rnd_word(), rnd_word(), rnd_word(), 1'($urandom_range(1))));
                    k++;
                end
                default: begin
                    int np;
                    np = $urandom_range(1, 4);
                    for (int j = 0; j < np; j++) begin
                        send(point($urandom_range(32'h4_0000) - 32'h2_0000,
                                   $urandom_range(32'h4_0000) - 32'h2_0000,
                                   $urandom_range(32'h4_0000) - 32'h2_0000,
                                   j == np - 1));
                        k++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: defaults, extremes, zero divisor, behind, out of image, dropping, out-of-range loads
        send(point(32'h0, 32'h0, 32'h0005_0000, 1));
        send(point(32'h0, 32'h0, 32'h0, 1));
        send(point(32'h0001_0000, 32'h0, 32'hffff_0000, 0));
        send(point(32'h0, 32'h0, 32'h0005_0000, 0));
        send(point(32'h0, 32'h0, 32'h0005_0000, 1));
        send(point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0100, 1));
        send(point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1));
        send(point(32'h0, 32'h0, 32'h0, 0));
        send(point(32'h0, 32'h0, 32'h0005_0000, 1));
        send(load_item(OP_SENSOR, 15, 32'h1234_5678));
        send(load_item(OP_SCALE, 7, 32'h1234_5678));
        send(load_item(OP_SCALE, 2, 32'h0002_0000));
        send(load_item(OP_LANDMARK, 11, 32'h0001_0000));
        send(load_item(OP_SENSOR, 3, 32'hffff_0000));
        send(point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1));
        send(point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1));
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                default: begin send_idle = 24; recv_stall = 24; end
            endcase
            case (ph)
                1: begin
                    write_reg(REG_FX, 32'h0);
                    write_reg(REG_FY, 32'h7fff_ffff);
                    write_reg(REG_SK, 32'h8000_0000);
                    write_reg(REG_MD, 32'h0);
                end
                2: begin
                    write_reg(REG_FX, 32'h7fff_ffff);
                    write_reg(REG_CX, 32'h7fff_ffff);
                    write_reg(REG_CY, 32'h0);
                    write_reg(REG_W, 32'h0000_ffff);
                    write_reg(REG_H, 32'h0000_0001);
                    write_reg(REG_SK, 32'h7fff_ffff);
                end
                3: begin
                    write_reg(REG_MD, 32'h7fff_ffff);
                    write_reg(REG_W, 32'h1);
                    write_reg(REG_H, 32'hffff);
                end
                default: begin
                    write_reg(REG_FX, $urandom_range(32'h400_0000));
                    write_reg(REG_FY, $urandom_range(32'h400_0000));
                    write_reg(REG_CX, $urandom_range(32'h400_0000));
                    write_reg(REG_CY, $urandom_range(32'h300_0000));
                    write_reg(REG_SK, $urandom_range(32'h2_0000) - 32'h1_0000);
                    write_reg(REG_W, $urandom_range(1, 2000));
                    write_reg(REG_H, $urandom_range(1, 2000));
                    write_reg(REG_MD, $urandom_range(32'h2_0000));
                end
            endcase
            cfg_valid <= 0;
            random_phase(135);
            settle();
        end

        if (fail_count == 0)
            $display("PASS pinhole_point_projection");
        else
            $display("FAIL pinhole_point_projection");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/ppp_pkg.sv
src/ppp_datapath.sv
src/ppp_control.sv
src/pinhole_point_projection.sv
sim/ppp_checker.sv
sim/testbench.sv
